// File: hw/rtl/stdt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the smoothed temperature trend detector.
// No dependencies; every other file of the block imports this package.
package stdt_pkg;

  // Field widths
  localparam int SampleW = 11;   // raw sample, tenths of a degree, signed
  localparam int TempW   = 15;   // smoothed value, 1/160 degree, signed
  localparam int CoefW   = 15;   // |smoothed - reference|
  localparam int TrendW  = 2;
  localparam int ThreshW = 11;
  localparam int LimitW  = 8;
  localparam int CountW  = 8;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 11;

  // Tenths of a degree to 1/160 degree: multiply by sixteen
  localparam int ScaleShift = 4;

  // Smoothing weight: new = (old*(D-1) + sample) / D, D a power of two
  localparam int SmoothShift   = 2;
  localparam int SmoothDivisor = 1 << SmoothShift;

  // Weighted sum needs room for D times the largest magnitude plus sign
  localparam int AccW  = TempW + SmoothShift + 1;
  localparam int DiffW = TempW + 1;

  // Reset values of the configuration registers
  localparam logic [ThreshW-1:0] ThreshReset      = ThreshW'(16);
  localparam logic [LimitW-1:0]  RiseLimitReset   = LimitW'(3);
  localparam logic [LimitW-1:0]  DropLimitReset   = LimitW'(3);
  localparam logic [LimitW-1:0]  StableLimitReset = LimitW'(10);

  typedef enum logic [TrendW-1:0] {
    TrendStable = 2'd0,
    TrendRise   = 2'd1,
    TrendDrop   = 2'd2
  } trend_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgChangeThreshold = 2'd0,
    CfgRiseLimit       = 2'd1,
    CfgDropLimit       = 2'd2,
    CfgStableLimit     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ThreshW-1:0] diff_thresh;
    logic [LimitW-1:0]  rise_limit;
    logic [LimitW-1:0]  drop_limit;
    logic [LimitW-1:0]  stable_limit;
  } cfg_t;

  typedef struct packed {
    logic                      valid;
    logic signed [SampleW-1:0] sample;
  } core_req_t;

  typedef struct packed {
    logic signed [TempW-1:0] smoothed_temp;
    trend_e                  trend;
    logic [CoefW-1:0]        coefficient;
  } result_t;

endpackage

// File: hw/rtl/stdt_sample_if.sv
`timescale 1ns / 1ps
// Sample channel: valid/ready handshake carrying one temperature word.
// Depends on stdt_pkg for the field widths.
interface stdt_sample_if import stdt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;
  logic                      sample_valid;

  modport source (output valid, output sample, output sample_valid, input ready);
  modport sink   (input valid, input sample, input sample_valid, output ready);
endinterface

// File: hw/rtl/stdt_result_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one smoothed/trend word.
// Depends on stdt_pkg for the field widths.
interface stdt_result_if import stdt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [TempW-1:0] smoothed_temp;
  logic [TrendW-1:0]       trend;
  logic [CoefW-1:0]        coefficient;

  modport source (output valid, output smoothed_temp, output trend, output coefficient,
                  input ready);
  modport sink   (input valid, input smoothed_temp, input trend, input coefficient,
                  output ready);
endinterface

// File: hw/rtl/stdt_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: register index and write data with valid/ready.
// Depends on stdt_pkg for the field widths.
interface stdt_cfg_if import stdt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/stdt_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register bank: threshold and the three trend limits.
// Depends on stdt_pkg and stdt_cfg_if.
module stdt_cfg_regs import stdt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  stdt_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.diff_thresh  <= ThreshReset;
      cfg_q.rise_limit   <= RiseLimitReset;
      cfg_q.drop_limit   <= DropLimitReset;
      cfg_q.stable_limit <= StableLimitReset;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CfgChangeThreshold: cfg_q.diff_thresh  <= cfg_i.data[ThreshW-1:0];
        CfgRiseLimit:       cfg_q.rise_limit   <= cfg_i.data[LimitW-1:0];
        CfgDropLimit:       cfg_q.drop_limit   <= cfg_i.data[LimitW-1:0];
        CfgStableLimit:     cfg_q.stable_limit <= cfg_i.data[LimitW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/stdt_trend_core.sv
`timescale 1ns / 1ps
// Smoothing and trend state with the result register.
// Depends on stdt_pkg.
module stdt_trend_core import stdt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  core_req_t req_i,
  output logic      req_ready_o,
  input  logic      res_ready_i,
  output logic      res_valid_o,
  output result_t   res_o
);

  // Weight of the old value; also the bias that turns the shift into
  // truncation toward zero for negative sums.
  localparam logic signed [AccW-1:0] KeepWeight = AccW'(SmoothDivisor - 1);

  logic signed [TempW-1:0] smooth_q, smooth_d;
  logic signed [TempW-1:0] ref_q, ref_d;
  logic                    primed_q;
  logic [CountW-1:0]       rise_cnt_q, rise_cnt_d;
  logic [CountW-1:0]       drop_cnt_q, drop_cnt_d;
  logic [CountW-1:0]       stable_cnt_q, stable_cnt_d;
  trend_e                  last_trend_q, trend_d;
  logic                    res_valid_q;
  result_t                 res_q;

  logic signed [TempW-1:0] scaled;
  logic signed [AccW-1:0]  acc, acc_biased, avg;
  logic signed [TempW-1:0] ref_base;
  logic signed [DiffW-1:0] diff, neg_diff, thresh;
  logic [CoefW-1:0]        coef;
  logic                    is_rise, is_drop;
  logic [CountW-1:0]       rise_inc, drop_inc, stable_inc;
  logic                    fire;

  assign req_ready_o = !res_valid_q || res_ready_i;
  assign fire        = req_i.valid && req_ready_o;

  // Smoothing
  assign scaled     = TempW'(req_i.sample) <<< ScaleShift;
  assign acc        = AccW'(smooth_q) * KeepWeight + AccW'(scaled);
  assign acc_biased = acc[AccW-1] ? acc + KeepWeight : acc;
  assign avg        = acc_biased >>> SmoothShift;
  assign smooth_d   = primed_q ? avg[TempW-1:0] : scaled;
  assign ref_base   = primed_q ? ref_q : scaled;

  // Deviation from the reference
  assign diff     = DiffW'(smooth_d) - DiffW'(ref_base);
  assign neg_diff = -diff;
  assign coef     = diff[DiffW-1] ? neg_diff[CoefW-1:0] : diff[CoefW-1:0];
  assign thresh   = $signed(DiffW'(cfg_i.diff_thresh));
  assign is_rise  = diff > thresh;
  assign is_drop  = neg_diff > thresh;

  assign rise_inc   = rise_cnt_q + 1'b1;
  assign drop_inc   = drop_cnt_q + 1'b1;
  assign stable_inc = stable_cnt_q + 1'b1;

  always_comb begin
    ref_d        = ref_base;
    rise_cnt_d   = rise_cnt_q;
    drop_cnt_d   = drop_cnt_q;
    stable_cnt_d = stable_cnt_q;
    trend_d      = last_trend_q;
    if (is_rise) begin
      rise_cnt_d = rise_inc;
      if (rise_inc >= cfg_i.rise_limit) begin
        ref_d        = smooth_d;
        rise_cnt_d   = '0;
        drop_cnt_d   = '0;
        stable_cnt_d = '0;
        trend_d      = TrendRise;
      end
    end else if (is_drop) begin
      drop_cnt_d = drop_inc;
      if (drop_inc >= cfg_i.drop_limit) begin
        ref_d        = smooth_d;
        rise_cnt_d   = '0;
        drop_cnt_d   = '0;
        stable_cnt_d = '0;
        trend_d      = TrendDrop;
      end
    end else begin
      stable_cnt_d = stable_inc;
      if (stable_inc >= cfg_i.stable_limit) begin
        if (last_trend_q != TrendStable) begin
          ref_d = smooth_d;
        end
        rise_cnt_d   = '0;
        drop_cnt_d   = '0;
        stable_cnt_d = '0;
        trend_d      = TrendStable;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q     <= '0;
      ref_q        <= '0;
      primed_q     <= 1'b0;
      rise_cnt_q   <= '0;
      drop_cnt_q   <= '0;
      stable_cnt_q <= '0;
      last_trend_q <= TrendStable;
      res_valid_q  <= 1'b0;
    end else begin
      if (fire) begin
        smooth_q     <= smooth_d;
        ref_q        <= ref_d;
        primed_q     <= 1'b1;
        rise_cnt_q   <= rise_cnt_d;
        drop_cnt_q   <= drop_cnt_d;
        stable_cnt_q <= stable_cnt_d;
        last_trend_q <= trend_d;
      end
      if (req_ready_o) begin
        res_valid_q <= req_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q.smoothed_temp <= smooth_d;
      res_q.trend         <= trend_d;
      res_q.coefficient   <= coef;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: hw/rtl/smoothed_temperature_trend_detector_unit.sv
`timescale 1ns / 1ps
// Top level of the smoothed temperature trend detector: input register,
// trend core, configuration bank. Depends on stdt_pkg, the three channel
// interfaces, stdt_cfg_regs and stdt_trend_core.
//
// The block takes one temperature word per clock while results are accepted
// and returns one result word for every word whose sample_valid bit is set;
// words with sample_valid clear are dropped without touching any state. A
// word is held in the input register and is then folded into the smoothed
// value, classified and written to the result register, where its result
// word waits until it is accepted; while the output does not stall, the
// sustained rate is one word per cycle. That rate is set by the state update
// loop (smoothed value, reference, three counters, last trend), which closes
// combinationally between the input and result registers. A stalled result
// register holds the next valid word in the input register; a dropped word
// never waits. Configuration writes are always taken and should only be
// issued while no word is in flight.
module smoothed_temperature_trend_detector_unit import stdt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  stdt_cfg_if.sink      cfg_i,
  stdt_sample_if.sink   sample_i,
  stdt_result_if.source result_o
);

  cfg_t                      cfg;
  logic                      in_valid_q;
  logic signed [SampleW-1:0] in_sample_q;
  logic                      in_sv_q;
  core_req_t                 core_req;
  logic                      core_ready;
  logic                      core_fire;
  logic                      res_valid;
  result_t                   res;

  stdt_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Input register: take a new word when empty or when the held one leaves this
  // cycle, either into the core or because it is to be dropped.
  assign sample_i.ready = !in_valid_q || !in_sv_q || core_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      in_valid_q <= sample_i.valid;
    end
  end

  // Hold the payload until the next word is taken
  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      in_sample_q <= sample_i.sample;
      in_sv_q     <= sample_i.sample_valid;
    end
  end

  // Only words with a good sensor read reach the core
  assign core_req.valid  = in_valid_q && in_sv_q;
  assign core_req.sample = in_sample_q;
  assign core_fire       = core_req.valid && core_ready;

  stdt_trend_core u_trend_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_i       (core_req),
    .req_ready_o (core_ready),
    .res_ready_i (result_o.ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign result_o.valid         = res_valid;
  assign result_o.smoothed_temp = res.smoothed_temp;
  assign result_o.trend         = res.trend;
  assign result_o.coefficient   = res.coefficient;

  // A word taken by the core shows up in the result register next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_fire |=> result_o.valid)
    else $error("core took a word but no result followed");

  // A word marked invalid never blocks the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !in_sv_q) |-> sample_i.ready)
    else $error("dropped word stalled the input register");

  // A fresh result must come from a word the core took the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(core_fire))
    else $error("result appeared without a word entering the core");

endmodule

// File: sim/smoothed_temperature_trend_detector_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for smoothed_temperature_trend_detector_unit: drives sample
// and configuration words, predicts every result word and compares them field by field.
// Depends on stdt_pkg, stdt_sample_if, stdt_result_if, stdt_cfg_if and the block itself.
module smoothed_temperature_trend_detector_unit_tb;
  import stdt_pkg::*;

  // Idle time after the last expected result before touching the registers
  localparam int SettleCycles = 6;
  // Valid words per random phase, eight phases in all
  localparam int PhaseWords = 154;
  localparam int NumPhases  = 8;

  // Predicts the result word of each accepted sample word and holds the
  // expectations until the block returns them.
  class trend_predictor;
    int     threshold;
    int     rise_lim;
    int     drop_lim;
    int     stable_lim;
    int     smoothed;
    int     reference;
    bit     primed;
    int     rise_cnt;
    int     drop_cnt;
    int     stable_cnt;
    trend_e last_trend;
    result_t expected_results[$];
    int     mismatches;

    function new();
      threshold  = int'(ThreshReset);
      rise_lim   = int'(RiseLimitReset);
      drop_lim   = int'(DropLimitReset);
      stable_lim = int'(StableLimitReset);
      smoothed   = 0;
      reference  = 0;
      primed     = 1'b0;
      rise_cnt   = 0;
      drop_cnt   = 0;
      stable_cnt = 0;
      last_trend = TrendStable;
      mismatches = 0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [CfgDataW-1:0] value);
      case (idx)
        CfgChangeThreshold: threshold  = int'(value);
        CfgRiseLimit:       rise_lim   = int'(value[LimitW-1:0]);
        CfgDropLimit:       drop_lim   = int'(value[LimitW-1:0]);
        CfgStableLimit:     stable_lim = int'(value[LimitW-1:0]);
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [SampleW-1:0] raw, logic usable);
      int      scaled;
      int      diff;
      int      mag;
      trend_e  next;
      result_t r;
      if (!usable) return;
      scaled = raw;
      scaled = scaled * 16;
      if (!primed) begin
        smoothed  = scaled;
        reference = scaled;
        primed    = 1'b1;
      end else begin
        // Integer division truncates toward zero, as the block must
        smoothed = (smoothed * (SmoothDivisor - 1) + scaled) / SmoothDivisor;
      end
      diff = smoothed - reference;
      mag  = (diff < 0) ? -diff : diff;
      next = last_trend;
      if (diff > threshold) begin
        rise_cnt = (rise_cnt + 1) & 255;
        if (rise_cnt >= rise_lim) begin
          reference = smoothed;
          rise_cnt = 0; drop_cnt = 0; stable_cnt = 0;
          next = TrendRise;
        end
      end else if (-diff > threshold) begin
        drop_cnt = (drop_cnt + 1) & 255;
        if (drop_cnt >= drop_lim) begin
          reference = smoothed;
          rise_cnt = 0; drop_cnt = 0; stable_cnt = 0;
          next = TrendDrop;
        end
      end else begin
        stable_cnt = (stable_cnt + 1) & 255;
        if (stable_cnt >= stable_lim) begin
          if (last_trend != TrendStable) reference = smoothed;
          rise_cnt = 0; drop_cnt = 0; stable_cnt = 0;
          next = TrendStable;
        end
      end
      last_trend      = next;
      r.smoothed_temp = TempW'(smoothed);
      r.trend         = next;
      r.coefficient   = CoefW'(mag);
      expected_results.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic signed [TempW-1:0] temp, logic [TrendW-1:0] trend,
                      logic [CoefW-1:0] coef);
      result_t want;
      if (expected_results.size() == 0) begin
        report("result word with no expectation waiting");
        return;
      end
      want = expected_results.pop_front();
      if (temp !== want.smoothed_temp)
        report($sformatf("smoothed_temp %0d, expected %0d", temp, want.smoothed_temp));
      if (trend !== want.trend)
        report($sformatf("trend %0d, expected %0d", trend, want.trend));
      if (coef !== want.coefficient)
        report($sformatf("coefficient %0d, expected %0d", coef, want.coefficient));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  stdt_sample_if sample_if ();
  stdt_result_if result_if ();
  stdt_cfg_if    cfg_if ();

  trend_predictor trend_pred;

  // Sender burst bookkeeping and the temperature the random stream wanders around
  int burst_left = 0;
  int temp_level = 200;

  // Receiver stall pattern: one bit per cycle, refreshed when the phase counter wraps
  logic [15:0] stall_pattern = 16'h0000;
  logic [5:0]  stall_phase   = 6'd0;

  smoothed_temperature_trend_detector_unit u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .sample_i (sample_if),
    .result_o (result_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver: check each accepted result word, then drive ready from the stall
  // pattern. Bit 0 of a pattern is always clear, so ready is driven high at least once per pass.
  always @(posedge clk_i) begin
    if (result_if.valid && result_if.ready)
      trend_pred.check_result(result_if.smoothed_temp, result_if.trend,
                              result_if.coefficient);
    stall_phase <= stall_phase + 6'd1;
    if (stall_phase == 6'd63)
      stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'h0000 : (16'($urandom) & 16'hFFFE);
    result_if.ready <= !stall_pattern[stall_phase[3:0]];
  end

  // Offer one sample word and hold it until the block takes it. Open a new
  // burst with a random gap first when the current one is used up; now and
  // then make the burst long so that stretches run with no idling at all.
  task automatic offer_sample(int value, bit usable);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        sample_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
    end
    burst_left--;
    sample_if.valid        <= 1'b1;
    sample_if.sample       <= SampleW'(value);
    sample_if.sample_valid <= usable;
    do @(posedge clk_i); while (!sample_if.ready);
    trend_pred.note_sample(SampleW'(value), usable);
  endtask

  // Stop sending, wait for every expected word, then let dropped words settle
  task automatic drain_results();
    sample_if.valid <= 1'b0;
    while (trend_pred.expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    burst_left = 0;
  endtask

  // Hold one register write until taken; valid stays high for the next write
  task automatic write_cfg_word(cfg_idx_e idx, int value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= CfgDataW'(value);
    do @(posedge clk_i); while (!cfg_if.ready);
    trend_pred.set_register(idx, CfgDataW'(value));
  endtask

  task automatic apply_settings(int thresh, int rise, int drop, int stable);
    write_cfg_word(CfgChangeThreshold, thresh);
    write_cfg_word(CfgRiseLimit, rise);
    write_cfg_word(CfgDropLimit, drop);
    write_cfg_word(CfgStableLimit, stable);
    cfg_if.valid <= 1'b0;
  endtask

  // Random stream of temperature segments: ramps up and down, steady
  // stretches with a little noise, and jumps across the nominal or the full
  // range. Clamping at the rails keeps ramps sitting on the field extremes.
  // About one word in twelve is a dropped word carrying arbitrary bits.
  task automatic run_random_stream(int valid_words);
    int made;
    int mode;
    int seg;
    int stride;
    int k;
    made = 0;
    while (made < valid_words) begin
      mode   = $urandom_range(0, 9);
      seg    = $urandom_range(4, 30);
      stride = $urandom_range(1, 40);
      for (k = 0; k < seg && made < valid_words; k++) begin
        case (mode)
          0, 1, 2: temp_level += stride;
          3, 4, 5: temp_level -= stride;
          6, 7:    temp_level += $urandom_range(0, 6) - 3;
          8:       temp_level = $urandom_range(0, 2047) - 1024;
          default: temp_level = $urandom_range(0, 1200) - 400;
        endcase
        if (temp_level > 1023) temp_level = 1023;
        if (temp_level < -1024) temp_level = -1024;
        if ($urandom_range(0, 11) == 0) begin
          offer_sample($urandom_range(0, 2047), 1'b0);
        end else begin
          offer_sample(temp_level, 1'b1);
          made++;
        end
        // Now and then hold the sender until the result side has caught up
        if ($urandom_range(0, 299) == 0) drain_results();
      end
    end
  endtask

  initial begin
    int phase;
    trend_pred = new();
    rst_ni                 <= 1'b0;
    sample_if.valid        <= 1'b0;
    sample_if.sample       <= '0;
    sample_if.sample_valid <= 1'b0;
    cfg_if.valid           <= 1'b0;
    cfg_if.index           <= CfgChangeThreshold;
    cfg_if.data            <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under reset settings: a dropped word before priming, the
    // priming word at the negative rail, a climb to the positive rail that
    // reports a rise, a dropped word, a fall that reports a drop, then a jump
    // up and a settle toward zero that ends in a dropped word.
    offer_sample(-1024, 1'b0);
    offer_sample(-1024, 1'b1);
    repeat (4) offer_sample(1023, 1'b1);
    offer_sample(1023, 1'b0);
    repeat (4) offer_sample(-400, 1'b1);
    offer_sample(800, 1'b1);
    offer_sample(0, 1'b1);
    repeat (10) offer_sample(0, 1'b1);
    offer_sample(0, 1'b0);
    drain_results();

    // Random phases, each under its own settings. The fixed ones cover the
    // extremes: zero threshold with limits of one, widest threshold with
    // limits of 255, and limits of zero written with high data bits set.
    for (phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: apply_settings(0, 1, 1, 1);
        1: apply_settings(2047, 255, 255, 255);
        2: apply_settings(1600, 11'h700, 11'h500, 11'h600);
        3: apply_settings(16, 3, 3, 10);
        4: apply_settings(8, 2, 5, 255);
        default:
          apply_settings(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                     : $urandom_range(0, 64),
                         $urandom_range(0, 2047) & 11'h70F,
                         $urandom_range(0, 2047) & 11'h70F,
                         $urandom_range(0, 2047) & 11'h71F);
      endcase
      run_random_stream(PhaseWords);
      drain_results();
    end

    if (trend_pred.mismatches == 0 && trend_pred.expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #(5_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule
